@@ sv/lrukvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrukvc_pkg
// Shared constants and controller/datapath handshake types for the LRU
// key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan results
        logic scan_rd;   // read entry at rd_addr for key compare
        logic commit;    // write key/value, set valid, fix update target
        logic upd_rd;    // read entry at rd_addr for age update
        logic out_load;  // move result into output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic req_put;   // latched request is a put
        logic found;     // scan found the key
        logic out_free;  // output register can take a word this cycle
    } sts_t;

endpackage

`default_nettype wire

@@ sv/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
//
//   channel  | ports                         | dir | handshake
//   ---------+-------------------------------+-----+-----------------------
//   request  | s_func, s_key, s_value        | in  | s_valid / s_ready
//   result   | m_hit, m_data                 | out | m_valid / m_ready
//   config   | cfg_wr_data (capacity)        | in  | cfg_wr_en, no wait
//
// A get miss sweeps the entry memories once, for key compare; every other
// request sweeps them twice: once for key compare and once to update the
// ages. Each sweep reads the entries one by one through one read address.
// s_ready is high only while the sequencer is idle; a finished word waits in
// the output register while the next request is already being worked on.
// Reset empties the cache at once and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lrukvc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [lrukvc_pkg::CAP_W-1:0]         cfg_wr_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_func,
    input  wire logic signed [lrukvc_pkg::KEY_W-1:0]  s_key,
    input  wire logic signed [lrukvc_pkg::VAL_W-1:0]  s_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_hit,
    output logic signed [lrukvc_pkg::VAL_W-1:0]       m_data
);

    logic [$clog2(MAX_ENTRIES)-1:0] rd_addr;
    lrukvc_pkg::cmd_t               cmd;
    lrukvc_pkg::sts_t               sts;

    lrukvc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .rd_addr (rd_addr),
        .cmd     (cmd),
        .sts     (sts)
    );

    lrukvc_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_func      (s_func),
        .s_key       (s_key),
        .s_value     (s_value),
        .rd_addr     (rd_addr),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_data      (m_data)
    );

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in progress");

    // a loaded result shows up on the result channel
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise m_valid");

    // result load only when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result word overwritten before it was taken");

    // commit happens while the input side is closed
    a_commit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s_ready)
        else $error("commit while accepting requests");

endmodule

`default_nettype wire

@@ sv/lrukvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrukvc_ctrl
// Sequencer: accept a request, sweep the entries for the key, commit the
// write, sweep again to age them (not on a get miss), then hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukvc_ctrl #(
    parameter int MAX_ENTRIES = lrukvc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    output logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr,
    output lrukvc_pkg::cmd_t                    cmd,
    input  wire lrukvc_pkg::sts_t               sts
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign rd_addr = cnt_reg[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg != LAST) begin
                    cmd.scan_rd = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    // last compare lands this cycle
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.commit = 1'b1;
                cnt_next   = '0;
                // a get miss changes nothing
                if (!sts.req_put && !sts.found) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (cnt_reg != LAST) begin
                    cmd.upd_rd = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // hold until the output register frees up
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lrukvc_dpath.sv @@
// ----------------------------------------------------------------------------
// lrukvc_dpath
// Entry storage (key, value and age memories, valid flops), key compare,
// LRU and free-slot search, age update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukvc_dpath #(
    parameter int MAX_ENTRIES = lrukvc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [lrukvc_pkg::CAP_W-1:0]         cfg_wr_data,
    input  wire logic                                 s_func,
    input  wire logic signed [lrukvc_pkg::KEY_W-1:0]  s_key,
    input  wire logic signed [lrukvc_pkg::VAL_W-1:0]  s_value,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]       rd_addr,
    input  wire lrukvc_pkg::cmd_t                     cmd,
    output lrukvc_pkg::sts_t                          sts,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_hit,
    output logic signed [lrukvc_pkg::VAL_W-1:0]       m_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int UW = (CW > lrukvc_pkg::CAP_W) ? CW : lrukvc_pkg::CAP_W;
    localparam int KW = lrukvc_pkg::KEY_W;
    localparam int VW = lrukvc_pkg::VAL_W;

    // configuration and request
    logic [lrukvc_pkg::CAP_W-1:0] cap_reg;
    logic                         req_func_reg;
    logic [KW-1:0]                req_key_reg;
    logic [VW-1:0]                req_value_reg;

    // entry storage
    logic [KW-1:0]          key_mem [MAX_ENTRIES];
    logic [VW-1:0]          val_mem [MAX_ENTRIES];
    logic [AW-1:0]          age_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CW-1:0]          used_reg;

    // registered read port
    logic [KW-1:0] key_q_reg;
    logic [VW-1:0] val_q_reg;
    logic [AW-1:0] age_q_reg;
    logic          vld_q_reg;
    logic [AW-1:0] idx_d_reg;
    logic          scan_pend_reg;
    logic          upd_pend_reg;

    // scan results
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [AW-1:0] hit_age_reg;
    logic [VW-1:0] hit_val_reg;
    logic          lru_any_reg;
    logic [AW-1:0] lru_idx_reg;
    logic [AW-1:0] lru_age_reg;
    logic          free_any_reg;
    logic [AW-1:0] free_idx_reg;

    // age update plan
    logic [AW-1:0] tgt_idx_reg, tgt_idx_next;
    logic [AW-1:0] thr_age_reg, thr_age_next;
    logic          inc_all_reg, inc_all_next;

    // result
    logic          res_hit_reg;
    logic [VW-1:0] res_data_reg, res_data_next;
    logic          m_valid_reg;
    logic          m_hit_reg;
    logic [VW-1:0] m_data_reg;

    // commit write controls
    logic          kv_we;
    logic          key_we;
    logic [AW-1:0] kv_addr;
    logic          insert;
    logic [UW-1:0] cap_ext;
    logic [UW-1:0] eff_cap;
    logic          full;

    // age write
    logic [AW-1:0] age_wdata;

    // ------------------------------------------------------------------
    // capacity register and request capture
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lrukvc_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_func_reg  <= s_func;
            req_key_reg   <= s_key;
            req_value_reg <= s_value;
        end
    end

    // zero reads as one, anything past the array saturates
    always_comb begin
        cap_ext = UW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = UW'(1);
        end else if (cap_ext > UW'(MAX_ENTRIES)) begin
            eff_cap = UW'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = UW'(used_reg) >= eff_cap;
    end

    // ------------------------------------------------------------------
    // commit decision
    // ------------------------------------------------------------------
    always_comb begin
        kv_we         = 1'b0;
        key_we        = 1'b0;
        kv_addr       = hit_idx_reg;
        insert        = 1'b0;
        tgt_idx_next  = hit_idx_reg;
        thr_age_next  = hit_age_reg;
        inc_all_next  = 1'b0;
        res_data_next = hit_reg ? hit_val_reg : '0;
        if (req_func_reg == lrukvc_pkg::FUNC_PUT) begin
            res_data_next = req_value_reg;
            kv_we         = cmd.commit;
            if (!hit_reg) begin
                key_we = cmd.commit;
                if (full) begin
                    // evict the oldest entry
                    kv_addr      = lru_idx_reg;
                    tgt_idx_next = lru_idx_reg;
                    thr_age_next = lru_age_reg;
                end else begin
                    kv_addr      = free_idx_reg;
                    tgt_idx_next = free_idx_reg;
                    inc_all_next = 1'b1;
                    insert       = cmd.commit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            tgt_idx_reg  <= tgt_idx_next;
            thr_age_reg  <= thr_age_next;
            inc_all_reg  <= inc_all_next;
            res_hit_reg  <= hit_reg;
            res_data_reg <= res_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
        end else if (insert) begin
            valid_reg[kv_addr] <= 1'b1;
            used_reg           <= used_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[kv_addr] <= req_key_reg;
        end
        key_q_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (kv_we) begin
            val_mem[kv_addr] <= req_value_reg;
        end
        val_q_reg <= val_mem[rd_addr];
    end

    // target goes to zero, younger (or all, on insert) entries age by one
    always_comb begin
        if (idx_d_reg == tgt_idx_reg) begin
            age_wdata = '0;
        end else if (vld_q_reg && (inc_all_reg || (age_q_reg < thr_age_reg))) begin
            age_wdata = age_q_reg + 1'b1;
        end else begin
            age_wdata = age_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_pend_reg) begin
            age_mem[idx_d_reg] <= age_wdata;
        end
        age_q_reg <= age_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        vld_q_reg <= valid_reg[rd_addr];
        idx_d_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_pend_reg <= 1'b0;
            upd_pend_reg  <= 1'b0;
        end else begin
            scan_pend_reg <= cmd.scan_rd;
            upd_pend_reg  <= cmd.upd_rd;
        end
    end

    // ------------------------------------------------------------------
    // scan: key match, oldest valid entry, first free slot
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hit_reg      <= 1'b0;
            lru_any_reg  <= 1'b0;
            free_any_reg <= 1'b0;
        end else if (scan_pend_reg) begin
            if (vld_q_reg && (key_q_reg == req_key_reg) && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_d_reg;
                hit_age_reg <= age_q_reg;
                hit_val_reg <= val_q_reg;
            end
            if (vld_q_reg && (!lru_any_reg || (age_q_reg > lru_age_reg))) begin
                lru_any_reg <= 1'b1;
                lru_idx_reg <= idx_d_reg;
                lru_age_reg <= age_q_reg;
            end
            if (!vld_q_reg && !free_any_reg) begin
                free_any_reg <= 1'b1;
                free_idx_reg <= idx_d_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hit_reg  <= res_hit_reg;
            m_data_reg <= res_data_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_data       = m_data_reg;

    assign sts.req_put  = (req_func_reg == lrukvc_pkg::FUNC_PUT);
    assign sts.found    = hit_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

@@ dv/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. A shadow copy of the
// cache (keys, values, ages, fill count, capacity) predicts hit and data for
// every accepted request. Each result word is checked against the oldest
// prediction. Capacity is changed between phases while the block is idle.
// Both handshake sides idle at random, with idle-free stretches and two long
// receiver holds that back the cache up into its request port.
// ----------------------------------------------------------------------------

module tb_lru_key_value_cache;

    import lrukvc_pkg::*;

    localparam int DEPTH      = MAX_ENTRIES_DEF;
    localparam int LIMIT      = 1_000_000;
    localparam int PHASE_REQS = 200;
    localparam int HOLD_LEN   = 300;
    localparam int POOL_SIZE  = 24;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] data;
    } result_t;

    class lru_scoreboard;
        logic [KEY_W-1:0] key_mem [DEPTH];
        logic [VAL_W-1:0] val_mem [DEPTH];
        bit               in_use  [DEPTH];
        int unsigned      age     [DEPTH];
        int unsigned      n_used;
        logic [CAP_W-1:0] capacity;
        result_t          expected_results [$];
        int               errors;
        int               accepted;
        int               hits;
        int               evictions;

        function new();
            capacity  = CAP_RESET;
            n_used    = 0;
            errors    = 0;
            accepted  = 0;
            hits      = 0;
            evictions = 0;
            foreach (in_use[i]) begin
                in_use[i] = 1'b0;
                age[i]    = 0;
            end
        endfunction

        function int unsigned usable_entries();
            if (capacity == 0)
                return 1;
            if (capacity > DEPTH)
                return DEPTH;
            return capacity;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Make idx most recent; entries that were more recent age by one.
        function void promote(int idx);
            for (int i = 0; i < DEPTH; i++)
                if (in_use[i] && i != idx && age[i] < age[idx])
                    age[i]++;
            age[idx] = 0;
        endfunction

        function void note_request(logic func, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            bit      found;
            int      idx;
            int      slot;
            result_t r;
            found = 1'b0;
            idx   = 0;
            for (int i = 0; i < DEPTH; i++)
                if (!found && in_use[i] && key_mem[i] == key) begin
                    found = 1'b1;
                    idx   = i;
                end
            r.hit = found;
            if (func == FUNC_GET) begin
                r.data = found ? val_mem[idx] : '0;
                if (found)
                    promote(idx);
            end else begin
                r.data = value;
                if (found) begin
                    val_mem[idx] = value;
                    promote(idx);
                end else if (n_used >= usable_entries()) begin
                    // full: overwrite the oldest entry in place
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (in_use[i] && (slot < 0 || age[i] > age[slot]))
                            slot = i;
                    key_mem[slot] = key;
                    val_mem[slot] = value;
                    promote(slot);
                    evictions++;
                end else begin
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (slot < 0 && !in_use[i])
                            slot = i;
                    for (int i = 0; i < DEPTH; i++)
                        if (in_use[i])
                            age[i]++;
                    key_mem[slot] = key;
                    val_mem[slot] = value;
                    in_use[slot]  = 1'b1;
                    age[slot]     = 0;
                    n_used++;
                end
            end
            if (found)
                hits++;
            accepted++;
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic hit, logic [VAL_W-1:0] data);
            result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result word hit=%0b data=%h with nothing pending",
                                 hit, data));
                return;
            end
            want = expected_results.pop_front();
            if (hit !== want.hit)
                report($sformatf("hit %0b, predicted %0b", hit, want.hit));
            if (data !== want.data)
                report($sformatf("data %h, predicted %h", data, want.data));
        endtask
    endclass

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]        cfg_wr_data = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic                    s_func      = FUNC_GET;
    logic signed [KEY_W-1:0] s_key       = '0;
    logic signed [VAL_W-1:0] s_value     = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic                    m_hit;
    logic signed [VAL_W-1:0] m_data;

    lru_scoreboard sb = new();
    bit            no_idle   = 1'b0;
    bit            hold_long = 1'b0;
    int            cycle_count = 0;
    int            n_settings  = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    lru_key_value_cache dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(func, key, value);
    endtask

    // Drop valid and wait until every word is back and the sequencer is idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 || !s_ready)
            @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.capacity = cap;
        n_settings++;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input bit idle_free,
                             input bit with_hold);
        int   span;
        int   pick;
        logic func;
        logic [KEY_W-1:0] key;
        set_capacity(cap);
        foreach (key_pool[i])
            key_pool[i] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 7))
                                                        : KEY_W'($urandom());
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = {1'b1, {(KEY_W-1){1'b0}}};
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = {1'b0, {(KEY_W-1){1'b1}}};
        span = sb.usable_entries() + $urandom_range(0, 4);
        if (span > POOL_SIZE)
            span = POOL_SIZE;
        no_idle   = idle_free;
        hold_long = with_hold;
        repeat (PHASE_REQS) begin
            pick = $urandom_range(0, 7);
            key  = (pick == 0) ? KEY_W'($urandom()) : key_pool[$urandom_range(0, span - 1)];
            func = ($urandom_range(0, 1) == 0) ? FUNC_GET : FUNC_PUT;
            send_request(func, key, VAL_W'($urandom()));
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, plus one long hold when asked
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                stall     = HOLD_LEN;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_hit, m_data);
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycle_count, sb.pending());
        $display("tb_lru_key_value_cache: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty cache, extreme keys and values, update in place
        send_request(FUNC_GET, 32'h0000_0000, 32'h1111_1111);
        send_request(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_1234);
        send_request(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_GET, 32'h0000_0005, 32'h0000_0000);

        // zero capacity acts as one, and sits below the current fill
        set_capacity(5'd0);
        send_request(FUNC_PUT, 32'h0000_0001, 32'h0000_0011);
        send_request(FUNC_PUT, 32'h0000_0002, 32'h0000_0022);
        send_request(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0002, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);

        // capacity above the entry count saturates
        set_capacity(5'd31);
        for (int i = 0; i < 7; i++)
            send_request(FUNC_PUT, 32'd100 + i, $urandom());
        send_request(FUNC_GET, 32'd100, 32'h0000_0000);
        send_request(FUNC_GET, 32'h8000_0000, 32'h0000_0000);

        run_phase(5'd31, 1'b0, 1'b0);
        run_phase(5'd16, 1'b0, 1'b0);
        run_phase(5'd2,  1'b0, 1'b0);
        run_phase(5'd0,  1'b1, 1'b0);
        run_phase(5'd1,  1'b0, 1'b0);
        run_phase(5'd4,  1'b1, 1'b1);
        run_phase(5'd17, 1'b0, 1'b0);
        run_phase(5'd8,  1'b0, 1'b1);
        run_phase(5'd3,  1'b0, 1'b0);
        run_phase(5'd16, 1'b1, 1'b0);

        wait_drained();
        repeat (2 * DEPTH + 10) @(posedge aclk);

        $display("Ran %0d requests across %0d capacity writes, including idle-free",
                 sb.accepted, n_settings);
        $display("stretches and long result holds: %0d hits, %0d evictions predicted.",
                 sb.hits, sb.evictions);
        if (sb.errors == 0)
            $display("tb_lru_key_value_cache: clean");
        else
            $display("tb_lru_key_value_cache: errors");
        $finish;
    end

endmodule
